// ===== rtl/mstc_pkg.sv =====
`default_nettype none

package mstc_pkg;

    localparam int VTX_W      = 3;
    localparam int WGT_W      = 16;
    localparam int COST_W     = 19;
    localparam int TAKEN_W    = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int EDGE_W     = 2 * VTX_W + WGT_W;
    localparam int M_FIELDS_W = COST_W + TAKEN_W + 1;

    // Packed so that the last field (a) lands in the lowest bits, matching tdata.
    typedef struct packed {
        logic [WGT_W-1:0] w;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] a;
    } edge_t;

    // Request from the edge sequencer to the union-find unit.
    typedef struct packed {
        logic             start;
        logic             clear;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
    } uf_ctrl_t;

    // Status back from the union-find unit.
    typedef struct packed {
        logic busy;
        logic done;
        logic joined;
    } uf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/min_spanning_tree_cost_core.sv =====
`default_nettype none

// Minimum spanning tree cost engine (Kruskal order, union-find forest).
//
// Input stream: one weighted undirected edge per beat. tdata carries
// vertex_a, vertex_b and edge_weight; tlast marks the final edge of the
// graph. Edges load at one per cycle while s_axis_tready is high. An edge
// with an endpoint at or above NUM_VERTICES is ignored; an edge that finds
// the store full is dropped and flags overflow.
// After the tlast beat, s_axis_tready drops while the engine runs. Each
// pass scans the edge RAM through its single read port for the next edge
// in (weight, arrival) order, then the union-find unit walks both
// endpoints to their roots, links them and reports back.
// Result stream: one beat per graph with total_cost, edges_taken and
// overflow in tdata. The result sits in an output register, so loading of
// the next graph starts at once even if the receiver stalls; only a
// second finished result waits until the first beat is taken.
// Reset (aresetn low, synchronous) empties the store, clears the forest,
// the cost and the overflow flag, and drops m_axis_tvalid.
module min_spanning_tree_cost_core #(
    parameter int NUM_VERTICES = 8,
    parameter int MAX_EDGES    = 32
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] vertex_a, [5:3] vertex_b, [21:6] edge_weight, [23:22] zero
    input  wire  [mstc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire                             s_axis_tlast,   // last_edge
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [18:0] total_cost, [21:19] edges_taken, [22] overflow, [23] zero
    output logic [mstc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import mstc_pkg::*;

    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW = WGT_W + IW;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_UNION = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Edge store: one write port for loading, one registered read port.
    edge_t edge_mem [MAX_EDGES];
    edge_t rd_data_reg;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;

    logic [CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;

    logic               have_best_reg, have_best_next;
    edge_t              best_edge_reg, best_edge_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic               have_prev_reg, have_prev_next;
    logic [WGT_W-1:0]   prev_w_reg, prev_w_next;
    logic [IW-1:0]      prev_idx_reg, prev_idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [COST_W-1:0]  out_cost_reg, out_cost_next;
    logic [TAKEN_W-1:0] out_taken_reg, out_taken_next;
    logic               out_ovf_reg, out_ovf_next;

    edge_t              in_edge;
    logic               s_fire;
    logic               in_range;
    logic               store_free;
    logic               mem_we;
    logic [IW-1:0]      rd_addr;
    logic [KW-1:0]      cand_key, prev_key, best_key;
    logic               cand_ok;
    logic               scan_end;

    uf_ctrl_t           uf_ctrl;
    uf_stat_t           uf_stat;

    assign in_edge    = edge_t'(s_axis_tdata[EDGE_W-1:0]);
    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign in_range   = (int'(in_edge.a) < NUM_VERTICES) && (int'(in_edge.b) < NUM_VERTICES);
    assign store_free = (count_reg < CW'(MAX_EDGES));
    assign mem_we     = s_fire && in_range && store_free;
    assign rd_addr    = scan_cnt_reg[IW-1:0];

    // Order by weight, then by arrival; the key is unique per stored edge.
    assign cand_key = {rd_data_reg.w, rd_idx_reg};
    assign prev_key = {prev_w_reg, prev_idx_reg};
    assign best_key = {best_edge_reg.w, best_idx_reg};
    assign cand_ok  = rd_vld_reg && (!have_prev_reg || (cand_key > prev_key))
                      && (!have_best_reg || (cand_key < best_key));
    assign scan_end = (state_reg == S_SCAN) && (scan_cnt_reg == count_reg) && !rd_vld_reg;

    assign uf_ctrl.start = scan_end && have_best_reg;
    assign uf_ctrl.clear = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);
    assign uf_ctrl.a     = best_edge_reg.a;
    assign uf_ctrl.b     = best_edge_reg.b;

    mstc_union_find #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_union_find (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (uf_ctrl),
        .stat    (uf_stat)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        cost_next      = cost_reg;
        taken_next     = taken_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_addr;
        have_best_next = have_best_reg;
        best_edge_next = best_edge_reg;
        best_idx_next  = best_idx_reg;
        have_prev_next = have_prev_reg;
        prev_w_next    = prev_w_reg;
        prev_idx_next  = prev_idx_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_cost_next  = out_cost_reg;
        out_taken_next = out_taken_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (in_range) begin
                        if (store_free) begin
                            count_next = count_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_axis_tlast) begin
                        scan_cnt_next  = '0;
                        have_best_next = 1'b0;
                        have_prev_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare the one that returns
                if (scan_cnt_reg != count_reg) begin
                    rd_vld_next   = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (cand_ok) begin
                    have_best_next = 1'b1;
                    best_edge_next = rd_data_reg;
                    best_idx_next  = rd_idx_reg;
                end
                if (scan_end) begin
                    if (have_best_reg) begin
                        have_prev_next = 1'b1;
                        prev_w_next    = best_edge_reg.w;
                        prev_idx_next  = best_idx_reg;
                        state_next     = S_UNION;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_UNION: begin
                if (uf_stat.done) begin
                    if (uf_stat.joined) begin
                        cost_next  = cost_reg + COST_W'(best_edge_reg.w);
                        taken_next = taken_reg + TAKEN_W'(1);
                    end
                    scan_cnt_next  = '0;
                    have_best_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_DONE: begin
                // hold until the output register is free, then clear the graph
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next   = 1'b1;
                    out_cost_next  = cost_reg;
                    out_taken_next = taken_reg;
                    out_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    cost_next      = '0;
                    taken_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            cost_reg      <= '0;
            taken_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            cost_reg      <= cost_next;
            taken_reg     <= taken_next;
            rd_vld_reg    <= rd_vld_next;
            have_best_reg <= have_best_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg  <= scan_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        best_edge_reg <= best_edge_next;
        best_idx_reg  <= best_idx_next;
        prev_w_reg    <= prev_w_next;
        prev_idx_reg  <= prev_idx_next;
        out_cost_reg  <= out_cost_next;
        out_taken_reg <= out_taken_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            edge_mem[count_reg[IW-1:0]] <= in_edge;
        end
        rd_data_reg <= edge_mem[rd_addr];
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                            out_ovf_reg, out_taken_reg, out_cost_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_EDGES)
        else $error("edge count beyond store depth");

    a_last_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_reg == S_SCAN))
        else $error("last edge did not start the scan");

    a_uf_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        uf_ctrl.start |-> !uf_stat.busy)
        else $error("union-find started while busy");

    a_union_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        uf_stat.done |-> (state_reg == S_UNION))
        else $error("union-find finished outside the union phase");

endmodule

`default_nettype wire

// ===== rtl/mstc_union_find.sv =====
`default_nettype none

module mstc_union_find #(
    parameter int NUM_VERTICES = 8
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire mstc_pkg::uf_ctrl_t  ctrl,
    output mstc_pkg::uf_stat_t       stat
);
    import mstc_pkg::*;

    localparam int RW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_RD   = 2'd1;
    localparam logic [1:0] U_CHK  = 2'd2;
    localparam logic [1:0] U_LINK = 2'd3;

    logic [RW-1:0]           root_mem [NUM_VERTICES];
    logic [RW-1:0]           rt_rd_reg;
    logic [NUM_VERTICES-1:0] vld_reg, vld_next;

    logic [1:0]    state_reg, state_next;
    logic [RW-1:0] cur_reg, cur_next;
    logic [RW-1:0] ra_reg, ra_next;
    logic [RW-1:0] rb_reg, rb_next;
    logic [RW-1:0] b_reg, b_next;
    logic          side_reg, side_next;
    logic          done_reg, done_next;
    logic          joined_reg, joined_next;

    logic [RW-1:0] parent;
    logic [RW-1:0] hi_root, lo_root;
    logic          link_we;

    // An entry never linked is its own root.
    assign parent  = vld_reg[cur_reg] ? rt_rd_reg : cur_reg;
    assign hi_root = (ra_reg > rb_reg) ? ra_reg : rb_reg;
    assign lo_root = (ra_reg > rb_reg) ? rb_reg : ra_reg;
    assign link_we = (state_reg == U_LINK) && (ra_reg != rb_reg);

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        b_next      = b_reg;
        side_next   = side_reg;
        done_next   = 1'b0;
        joined_next = joined_reg;
        vld_next    = vld_reg;
        case (state_reg)
            U_IDLE: begin
                if (ctrl.clear) begin
                    vld_next = '0;
                end
                if (ctrl.start) begin
                    cur_next   = RW'(ctrl.a);
                    b_next     = RW'(ctrl.b);
                    side_next  = 1'b0;
                    state_next = U_RD;
                end
            end
            U_RD: begin
                state_next = U_CHK;
            end
            U_CHK: begin
                if (parent == cur_reg) begin
                    if (!side_reg) begin
                        ra_next    = cur_reg;
                        cur_next   = b_reg;
                        side_next  = 1'b1;
                        state_next = U_RD;
                    end else begin
                        rb_next    = cur_reg;
                        state_next = U_LINK;
                    end
                end else begin
                    cur_next   = parent;
                    state_next = U_RD;
                end
            end
            U_LINK: begin
                // link the larger root under the smaller
                if (link_we) begin
                    vld_next[hi_root] = 1'b1;
                end
                joined_next = (ra_reg != rb_reg);
                done_next   = 1'b1;
                state_next  = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= U_IDLE;
            vld_reg    <= '0;
            done_reg   <= 1'b0;
            joined_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            vld_reg    <= vld_next;
            done_reg   <= done_next;
            joined_reg <= joined_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        b_reg    <= b_next;
        side_reg <= side_next;
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            root_mem[hi_root] <= lo_root;
        end
        rt_rd_reg <= root_mem[cur_reg];
    end

    assign stat.busy   = (state_reg != U_IDLE);
    assign stat.done   = done_reg;
    assign stat.joined = joined_reg;

endmodule

`default_nettype wire
